/* design/binary_lifting_path_minimum_unit_assert.svh */
// Assertion macros for the path minimum unit.
// Each check is sampled on the rising edge of aclk and is off while aresetn is low.
`ifndef BINARY_LIFTING_PATH_MINIMUM_UNIT_ASSERT_SVH
`define BINARY_LIFTING_PATH_MINIMUM_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BLPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BLPM_ASSERT_NOW(lbl, ante, cons, msg)
`define BLPM_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

/* design/blpm_pkg.sv */
package blpm_pkg;

    // Fixed field widths of the stream payload.
    localparam int NODE_W     = 10;
    localparam int DEPTH_W    = 10;
    localparam int WEIGHT_W   = 31;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 32;

    // Largest supported number of lifting levels and the index width it needs.
    localparam int MAX_LEVELS = 20;
    localparam int LIFT_IW    = 5;

    // Path minimum reported when no edge lies on the path.
    localparam logic [WEIGHT_W-1:0] NO_EDGE_VALUE = '1;

    // Kind of an input transaction, carried on s_tuser.
    typedef enum logic {
        FUNC_ATTACH = 1'b0,
        FUNC_QUERY  = 1'b1
    } func_t;

    // Smaller of edge weights x and y.
    function automatic logic [WEIGHT_W-1:0] min_weight(input logic [WEIGHT_W-1:0] x,
                                                       input logic [WEIGHT_W-1:0] y);
        return (x < y) ? x : y;
    endfunction

endpackage

/* design/blpm_ram.sv */
module blpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd0_addr,
    output logic [WIDTH-1:0]         rd0_data,
    input  logic [$clog2(DEPTH)-1:0] rd1_addr,
    output logic [WIDTH-1:0]         rd1_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and two read ports, read data registered.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd0_data <= mem[rd0_addr];
        rd1_data <= mem[rd1_addr];
    end

endmodule

/* design/binary_lifting_path_minimum_unit.sv */
// Attach: builds and writes back the child row, but never for node 0; no result.
// Query: the result is registered after lifting and climbing, or after lifting alone when it
// meets the other endpoint; a new accept waits while an older result is held.
// Both read the node row memory once per lifting level in each pass.
// With NODES below 1024 every transaction first runs the node-number reduction steps.
// After reset the row memory is cleared, one row a cycle, with s_tready low.
`include "binary_lifting_path_minimum_unit_assert.svh"

module binary_lifting_path_minimum_unit #(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0 up: node_a[9:0], node_b[19:10], weight[50:20], zero fill.
    input  logic [blpm_pkg::S_TDATA_W-1:0]  s_tdata,
    // Field: func (0 attach, 1 query).
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0 up: path_min[30:0], zero fill.
    output logic [blpm_pkg::M_TDATA_W-1:0]  m_tdata,
    // Field: no_edge.
    output logic                            m_tuser
);

    import blpm_pkg::*;

    // Largest shift k with NODES << k still a node number; used for reduction.
    function automatic int red_top_f(input int n);
        int k;
        k = 0;
        for (int i = 1; i < NODE_W; i++) begin
            if ((n << i) < (1 << NODE_W)) begin
                k = i;
            end
        end
        return k;
    endfunction

    localparam int  NW       = $clog2(NODES);
    localparam int  LVW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int  ANC_BASE = DEPTH_W;
    localparam int  MIN_BASE = DEPTH_W + LEVELS * NW;
    localparam int  ROW_W    = MIN_BASE + LEVELS * WEIGHT_W;
    localparam bit  RED_NEED = (NODES < (1 << NODE_W));
    localparam int  RED_TOP  = red_top_f(NODES);
    localparam int  RKW      = 4;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_START,
        ST_A_L0,
        ST_A_LV,
        ST_A_WR,
        ST_Q_CMP,
        ST_Q_LIFT,
        ST_Q_CLIMB,
        ST_Q_LAST,
        ST_Q_OUT
    } state_t;

    // Row layout: depth, then the ancestor of each level, then the jump minimum of each level.
    function automatic logic [DEPTH_W-1:0] row_depth(input logic [ROW_W-1:0] row);
        return row[DEPTH_W-1:0];
    endfunction

    function automatic logic [NW-1:0] row_anc(input logic [ROW_W-1:0] row,
                                              input logic [LVW-1:0]   l);
        return row[ANC_BASE + int'(l) * NW +: NW];
    endfunction

    function automatic logic [WEIGHT_W-1:0] row_min(input logic [ROW_W-1:0] row,
                                                    input logic [LVW-1:0]   l);
        return row[MIN_BASE + int'(l) * WEIGHT_W +: WEIGHT_W];
    endfunction

    state_t               state_reg;
    logic [NW-1:0]        clr_cnt_reg;
    func_t                func_reg;
    logic [NODE_W-1:0]    a_reg;
    logic [NODE_W-1:0]    b_reg;
    logic [WEIGHT_W-1:0]  weight_reg;
    logic [RKW-1:0]       red_k_reg;
    logic [LVW-1:0]       lvl_reg;
    logic [NW-1:0]        u_reg;
    logic [NW-1:0]        v_reg;
    logic [DEPTH_W-1:0]   diff_reg;
    logic [WEIGHT_W-1:0]  best_reg;
    logic                 no_edge_reg;
    logic [DEPTH_W-1:0]   child_depth_reg;
    logic [NW-1:0]        child_anc_reg [LEVELS];
    logic [WEIGHT_W-1:0]  child_min_reg [LEVELS];
    logic [NW-1:0]        last_anc_reg;
    logic [WEIGHT_W-1:0]  last_min_reg;
    logic                 m_tvalid_reg;
    logic [WEIGHT_W-1:0]  m_path_min_reg;
    logic                 m_no_edge_reg;

    logic [NW-1:0]        a_idx;
    logic [NW-1:0]        b_idx;
    logic [NODE_W:0]      red_sub;
    logic [NODE_W-1:0]    red_a;
    logic [NODE_W-1:0]    red_b;
    logic [ROW_W-1:0]     rd0_row;
    logic [ROW_W-1:0]     rd1_row;
    logic [NW-1:0]        rd0_addr;
    logic [NW-1:0]        rd1_addr;
    logic                 wr_en;
    logic [NW-1:0]        wr_addr;
    logic [ROW_W-1:0]     wr_data;
    logic [ROW_W-1:0]     child_row;
    logic [LVW-1:0]       lvl_prev;
    logic                 mid_is_child;
    logic [NW-1:0]        mid_anc;
    logic [WEIGHT_W-1:0]  mid_min;
    logic [WEIGHT_W-1:0]  lv_min;
    logic [DEPTH_W-1:0]   da;
    logic [DEPTH_W-1:0]   db;
    logic                 swap;
    logic [MAX_LEVELS-1:0] diff_ext;
    logic                 lift_bit;
    logic [NW-1:0]        u_anc;
    logic [NW-1:0]        v_anc;
    logic [WEIGHT_W-1:0]  u_min;
    logic [WEIGHT_W-1:0]  v_min;
    logic [NW-1:0]        lift_u;
    logic [WEIGHT_W-1:0]  lift_best;
    logic                 climb_take;
    logic [NW-1:0]        climb_u;
    logic [NW-1:0]        climb_v;
    logic [WEIGHT_W-1:0]  climb_best;
    logic [WEIGHT_W-1:0]  last_best;
    logic                 out_free;

    // Stream ports.
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_path_min_reg);
    assign m_tuser  = m_no_edge_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // Node numbers as memory addresses.
    assign a_idx = NW'(a_reg);
    assign b_idx = NW'(b_reg);

    // One restoring step of the reduction modulo NODES.
    assign red_sub = (NODE_W + 1)'(NODES) << red_k_reg;
    assign red_a   = ({1'b0, a_reg} >= red_sub) ? a_reg - red_sub[NODE_W-1:0] : a_reg;
    assign red_b   = ({1'b0, b_reg} >= red_sub) ? b_reg - red_sub[NODE_W-1:0] : b_reg;

    // Attach level: the mid node's row comes from memory, or from the rows being built
    // when the mid node is the child itself.
    assign lvl_prev     = lvl_reg - LVW'(1);
    assign mid_is_child = (last_anc_reg == a_idx);
    assign mid_anc      = mid_is_child ? last_anc_reg : row_anc(rd0_row, lvl_prev);
    assign mid_min      = mid_is_child ? last_min_reg : row_min(rd0_row, lvl_prev);
    assign lv_min       = min_weight(last_min_reg, mid_min);

    // Query start: the deeper endpoint goes first.
    assign da   = row_depth(rd0_row);
    assign db   = row_depth(rd1_row);
    assign swap = (da < db);

    // Lifting to equal depth; depth difference bits above the top level are ignored.
    assign diff_ext  = MAX_LEVELS'(diff_reg);
    assign lift_bit  = diff_ext[LIFT_IW'(lvl_reg)];
    assign u_anc     = row_anc(rd0_row, lvl_reg);
    assign v_anc     = row_anc(rd1_row, lvl_reg);
    assign u_min     = row_min(rd0_row, lvl_reg);
    assign v_min     = row_min(rd1_row, lvl_reg);
    assign lift_u    = lift_bit ? u_anc : u_reg;
    assign lift_best = lift_bit ? min_weight(best_reg, u_min) : best_reg;

    // Climbing to just below the common ancestor.
    assign climb_take = (u_anc != v_anc);
    assign climb_u    = climb_take ? u_anc : u_reg;
    assign climb_v    = climb_take ? v_anc : v_reg;
    assign climb_best = climb_take ? min_weight(best_reg, min_weight(u_min, v_min)) : best_reg;
    assign last_best  = min_weight(best_reg, min_weight(row_min(rd0_row, LVW'(0)),
                                                        row_min(rd1_row, LVW'(0))));

    // Child row assembled for the write back.
    always_comb begin
        child_row = '0;
        child_row[DEPTH_W-1:0] = child_depth_reg;
        for (int l = 0; l < LEVELS; l++) begin
            child_row[ANC_BASE + l * NW +: NW]             = child_anc_reg[l];
            child_row[MIN_BASE + l * WEIGHT_W +: WEIGHT_W] = child_min_reg[l];
        end
    end

    // Read addresses for the row the next state works on.
    always_comb begin
        case (state_reg)
            ST_START: begin
                rd0_addr = (func_reg == FUNC_QUERY) ? a_idx : b_idx;
                rd1_addr = b_idx;
            end
            ST_A_L0: begin
                rd0_addr = b_idx;
                rd1_addr = v_reg;
            end
            ST_A_LV: begin
                rd0_addr = mid_anc;
                rd1_addr = v_reg;
            end
            ST_Q_CMP: begin
                rd0_addr = swap ? b_idx : a_idx;
                rd1_addr = swap ? a_idx : b_idx;
            end
            ST_Q_LIFT: begin
                rd0_addr = lift_u;
                rd1_addr = v_reg;
            end
            ST_Q_CLIMB: begin
                rd0_addr = climb_u;
                rd1_addr = climb_v;
            end
            default: begin
                rd0_addr = u_reg;
                rd1_addr = v_reg;
            end
        endcase
    end

    // Writes: zero rows during the clearing pass, the child row at the end of an attach.
    assign wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_A_WR);
    assign wr_addr = (state_reg == ST_CLEAR) ? clr_cnt_reg : a_idx;
    assign wr_data = (state_reg == ST_CLEAR) ? '0 : child_row;

    blpm_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NODES)
    ) u_row_ram (
        .aclk     (aclk),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd0_addr (rd0_addr),
        .rd0_data (rd0_row),
        .rd1_addr (rd1_addr),
        .rd1_data (rd1_row)
    );

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // A finishing query reloads the result register in the same cycle instead.
            if (m_tvalid_reg && m_tready && (state_reg != ST_Q_OUT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_cnt_reg <= clr_cnt_reg + NW'(1);
                    if (clr_cnt_reg == NW'(NODES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        func_reg   <= func_t'(s_tuser);
                        a_reg      <= s_tdata[NODE_W-1:0];
                        b_reg      <= s_tdata[2*NODE_W-1:NODE_W];
                        weight_reg <= s_tdata[2*NODE_W+WEIGHT_W-1:2*NODE_W];
                        red_k_reg  <= RKW'(RED_TOP);
                        state_reg  <= RED_NEED ? ST_REDUCE : ST_START;
                    end
                end
                ST_REDUCE: begin
                    a_reg <= red_a;
                    b_reg <= red_b;
                    if (red_k_reg == '0) begin
                        state_reg <= ST_START;
                    end else begin
                        red_k_reg <= red_k_reg - RKW'(1);
                    end
                end
                ST_START: begin
                    if (func_reg == FUNC_QUERY) begin
                        state_reg <= ST_Q_CMP;
                    end else if (a_reg == '0) begin
                        // Node 0 stays the null ancestor.
                        state_reg <= ST_IDLE;
                    end else begin
                        state_reg <= ST_A_L0;
                    end
                end
                ST_A_L0: begin
                    child_depth_reg  <= row_depth(rd0_row) + DEPTH_W'(1);
                    child_anc_reg[0] <= b_idx;
                    child_min_reg[0] <= weight_reg;
                    last_anc_reg     <= b_idx;
                    last_min_reg     <= weight_reg;
                    lvl_reg          <= LVW'(1);
                    state_reg        <= (LEVELS == 1) ? ST_A_WR : ST_A_LV;
                end
                ST_A_LV: begin
                    child_anc_reg[lvl_reg] <= mid_anc;
                    child_min_reg[lvl_reg] <= lv_min;
                    last_anc_reg           <= mid_anc;
                    last_min_reg           <= lv_min;
                    if (lvl_reg == LVW'(LEVELS - 1)) begin
                        state_reg <= ST_A_WR;
                    end else begin
                        lvl_reg <= lvl_reg + LVW'(1);
                    end
                end
                ST_A_WR: begin
                    state_reg <= ST_IDLE;
                end
                ST_Q_CMP: begin
                    u_reg       <= swap ? b_idx : a_idx;
                    v_reg       <= swap ? a_idx : b_idx;
                    diff_reg    <= swap ? db - da : da - db;
                    best_reg    <= NO_EDGE_VALUE;
                    no_edge_reg <= (a_reg == b_reg);
                    lvl_reg     <= LVW'(LEVELS - 1);
                    state_reg   <= ST_Q_LIFT;
                end
                ST_Q_LIFT: begin
                    u_reg    <= lift_u;
                    best_reg <= lift_best;
                    if (lvl_reg == '0) begin
                        if (lift_u == v_reg) begin
                            state_reg <= ST_Q_OUT;
                        end else begin
                            lvl_reg   <= LVW'(LEVELS - 1);
                            state_reg <= ST_Q_CLIMB;
                        end
                    end else begin
                        lvl_reg <= lvl_reg - LVW'(1);
                    end
                end
                ST_Q_CLIMB: begin
                    u_reg    <= climb_u;
                    v_reg    <= climb_v;
                    best_reg <= climb_best;
                    if (lvl_reg == '0) begin
                        state_reg <= ST_Q_LAST;
                    end else begin
                        lvl_reg <= lvl_reg - LVW'(1);
                    end
                end
                ST_Q_LAST: begin
                    best_reg  <= last_best;
                    state_reg <= ST_Q_OUT;
                end
                ST_Q_OUT: begin
                    if (out_free) begin
                        m_path_min_reg <= best_reg;
                        m_no_edge_reg  <= no_edge_reg;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Node 0 is written only by the clearing pass.
    `BLPM_ASSERT_NOW(a_no_null_write, wr_en && (state_reg != ST_CLEAR), wr_addr != '0, "attach wrote the null node row")
    // A finished query waits while the previous result is still held.
    `BLPM_ASSERT_NEXT(a_result_held, (state_reg == ST_Q_OUT) && m_tvalid_reg && !m_tready, state_reg == ST_Q_OUT, "query result overwrote a pending result")
    // Equal endpoints always report the no-edge value.
    `BLPM_ASSERT_NOW(a_no_edge_value, m_tvalid_reg && m_no_edge_reg, m_path_min_reg == NO_EDGE_VALUE, "no_edge result without the no-edge value")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import blpm_pkg::*;

    localparam int NODE_COUNT      = 1024;
    localparam int LIFT_LEVELS     = 10;
    localparam int RANDOM_ITEMS    = 700;
    localparam int RX_HOLD_CYCLES  = 300;
    localparam int HOLD_QUERIES    = 40;
    localparam int WATCHDOG_CYCLES = 5000;

    typedef logic [NODE_W-1:0]   node_t;
    typedef logic [DEPTH_W-1:0]  depth_t;
    typedef logic [WEIGHT_W-1:0] weight_t;

    typedef struct {
        func_t   func;
        node_t   node_a;
        node_t   node_b;
        weight_t weight;
    } tree_op_t;

    typedef struct {
        weight_t path_min;
        logic    no_edge;
    } path_result_t;

    logic                  aclk;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;

    // Handshakes and result fields, sampled mid-cycle for the next rising edge.
    logic                  s_fire = 1'b0;
    logic                  m_fire = 1'b0;
    logic [M_TDATA_W-1:0]  m_word = '0;
    logic                  m_flag = 1'b0;

    // Predicted lifting tables and the path minimums still owed by the block.
    depth_t       depth_tbl [NODE_COUNT];
    node_t        anc_tbl   [LIFT_LEVELS][NODE_COUNT];
    weight_t      jmin_tbl  [LIFT_LEVELS][NODE_COUNT];
    path_result_t pending_path_mins [$];

    int error_count   = 0;
    int n_attach      = 0;
    int n_query       = 0;
    int n_results     = 0;
    int n_equal       = 0;
    int max_depth     = 0;
    int burst_left    = 0;
    int idle_cycles   = 0;
    int rx_cycle      = 0;
    int rx_hold_left  = 0;
    int rx_hold_ticket = 0;
    int rx_hold_served = 0;

    binary_lifting_path_minimum_unit #(
        .NODES  (NODE_COUNT),
        .LEVELS (LIFT_LEVELS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic weight_t lesser(weight_t x, weight_t y);
        return (x < y) ? x : y;
    endfunction

    // Hang a child under a parent and rebuild its rows level by level.
    function automatic void attach_rows(node_t child, node_t parent, weight_t w);
        node_t mid;
        if (child == '0) return;
        depth_tbl[child]   = depth_tbl[parent] + 1'b1;
        anc_tbl[0][child]  = parent;
        jmin_tbl[0][child] = w;
        for (int lvl = 1; lvl < LIFT_LEVELS; lvl++) begin
            mid = anc_tbl[lvl-1][child];
            anc_tbl[lvl][child]  = anc_tbl[lvl-1][mid];
            jmin_tbl[lvl][child] = lesser(jmin_tbl[lvl-1][child], jmin_tbl[lvl-1][mid]);
        end
        if (int'(depth_tbl[child]) > max_depth) max_depth = int'(depth_tbl[child]);
    endfunction

    // Lift to equal depth, then to just below the common ancestor, keeping the minimum.
    function automatic path_result_t path_min_of(node_t u, node_t v);
        path_result_t res;
        node_t        x, y, t, ax, ay;
        depth_t       diff;
        weight_t      best;
        res.no_edge = (u == v);
        x = u;
        y = v;
        if (depth_tbl[x] < depth_tbl[y]) begin
            t = x;
            x = y;
            y = t;
        end
        diff = depth_tbl[x] - depth_tbl[y];
        best = NO_EDGE_VALUE;
        for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
            if (diff[lvl]) begin
                best = lesser(best, jmin_tbl[lvl][x]);
                x = anc_tbl[lvl][x];
            end
        end
        if (x != y) begin
            for (int lvl = LIFT_LEVELS - 1; lvl >= 0; lvl--) begin
                ax = anc_tbl[lvl][x];
                ay = anc_tbl[lvl][y];
                if (ax != ay) begin
                    best = lesser(best, lesser(jmin_tbl[lvl][x], jmin_tbl[lvl][y]));
                    x = ax;
                    y = ay;
                end
            end
            best = lesser(best, lesser(jmin_tbl[0][x], jmin_tbl[0][y]));
        end
        res.path_min = best;
        return res;
    endfunction

    function automatic tree_op_t make_op(func_t f, node_t a, node_t b, weight_t w);
        tree_op_t op;
        op.func   = f;
        op.node_a = a;
        op.node_b = b;
        op.weight = w;
        return op;
    endfunction

    // Weights lean toward the extremes and small values so that ties show up.
    function automatic weight_t rand_weight();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return weight_t'(32'd2147483646);
            2: return weight_t'($urandom_range(0, 15));
            default: return weight_t'($urandom_range(0, 2147483646));
        endcase
    endfunction

    function automatic node_t rand_node();
        return node_t'($urandom_range(1, NODE_COUNT - 1));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Offer one transaction in bursts with random gaps; predict once it is accepted.
    task automatic send_op(input tree_op_t op);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op.func;
        s_tdata  <= S_TDATA_W'({op.weight, op.node_b, op.node_a});
        do @(posedge aclk); while (!s_fire);
        burst_left--;
        if (op.func == FUNC_ATTACH) begin
            attach_rows(op.node_a, op.node_b, op.weight);
            n_attach++;
        end else begin
            pending_path_mins = {pending_path_mins, path_min_of(op.node_a, op.node_b)};
            n_query++;
        end
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (pending_path_mins.size() != 0);
    endtask

    // Extremes of the fields, both functions and each corner case of the tables.
    task automatic test_directed();
        send_op(make_op(FUNC_QUERY,  10'd0,     10'd0,     '0));
        send_op(make_op(FUNC_QUERY,  10'h155,   10'h2AA,   '0));
        send_op(make_op(FUNC_ATTACH, 10'd0,     10'd3,     31'd7));
        send_op(make_op(FUNC_ATTACH, 10'd1,     10'd0,     31'd0));
        send_op(make_op(FUNC_ATTACH, 10'd2,     10'd1,     31'd2147483646));
        send_op(make_op(FUNC_ATTACH, 10'h3FF,   10'd2,     31'h2AAAAAAA));
        send_op(make_op(FUNC_ATTACH, 10'h155,   10'h3FF,   31'h55555555));
        send_op(make_op(FUNC_QUERY,  10'h155,   10'd1,     '0));
        send_op(make_op(FUNC_QUERY,  10'd1,     10'h155,   31'h7FFFFFFE));
        send_op(make_op(FUNC_QUERY,  10'h3FF,   10'h3FF,   '0));
        send_op(make_op(FUNC_ATTACH, 10'd3,     10'd1,     31'd5));
        send_op(make_op(FUNC_ATTACH, 10'h2AA,   10'd3,     31'h1234));
        // Endpoints in different branches meet at a common ancestor.
        send_op(make_op(FUNC_QUERY,  10'h155,   10'h2AA,   '0));
        // A parent that was never attached acts as a root of its own.
        send_op(make_op(FUNC_ATTACH, 10'd4,     10'd900,   31'd11));
        send_op(make_op(FUNC_QUERY,  10'd4,     10'h2AA,   '0));
        // A node attached to itself.
        send_op(make_op(FUNC_ATTACH, 10'd5,     10'd5,     31'd77));
        send_op(make_op(FUNC_QUERY,  10'd5,     10'd0,     '0));
        send_op(make_op(FUNC_QUERY,  10'd5,     10'd5,     '0));
        // Moving an inner node leaves its descendants with stale rows.
        send_op(make_op(FUNC_ATTACH, 10'd2,     10'd3,     31'd9));
        send_op(make_op(FUNC_QUERY,  10'h155,   10'h2AA,   '0));
        send_op(make_op(FUNC_QUERY,  10'h3FF,   10'd0,     '0));
    endtask

    // One long chain through every node, so depth differences use all lifting levels.
    task automatic test_deep_chain();
        node_t chain [$];
        node_t t;
        int    j, k, last;
        wait_drained();
        for (int i = 1; i < NODE_COUNT; i++) chain = {chain, node_t'(i)};
        for (int i = chain.size() - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = chain[i];
            chain[i] = chain[j];
            chain[j] = t;
        end
        send_op(make_op(FUNC_ATTACH, chain[0], '0, rand_weight()));
        for (int i = 1; i < chain.size(); i++) begin
            send_op(make_op(FUNC_ATTACH, chain[i], chain[i-1], rand_weight()));
            if (i % 20 == 0) begin
                j = $urandom_range(0, i);
                k = $urandom_range(0, i);
                send_op(make_op(FUNC_QUERY, chain[j], chain[k], rand_weight()));
            end
        end
        last = chain.size() - 1;
        send_op(make_op(FUNC_QUERY, chain[last], chain[0], '0));
        send_op(make_op(FUNC_QUERY, chain[last], chain[$urandom_range(0, 400)], '0));
        send_op(make_op(FUNC_QUERY, chain[700], chain[100], '0));
        // Self-attaching the deepest node pushes its depth past the top and wraps it.
        repeat (3) send_op(make_op(FUNC_ATTACH, chain[last], chain[last], rand_weight()));
        send_op(make_op(FUNC_QUERY, chain[last], chain[0], '0));
        send_op(make_op(FUNC_QUERY, chain[last], chain[last-1], '0));
        send_op(make_op(FUNC_QUERY, chain[0], chain[last], '0));
    endtask

    // Mostly well-formed trees with queries among their members, plus random noise.
    task automatic test_random_trees();
        node_t    tree_nodes [$];
        node_t    a, b, parent;
        tree_op_t op;
        int       sent, round_len, choice, sz;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            tree_nodes.delete();
            a = rand_node();
            send_op(make_op(FUNC_ATTACH, a, '0, rand_weight()));
            tree_nodes = {tree_nodes, a};
            sent++;
            round_len = $urandom_range(20, 80);
            for (int n = 0; n < round_len; n++) begin
                choice = $urandom_range(0, 99);
                sz = tree_nodes.size();
                if (choice < 55) begin
                    // Favoring recent members as parents grows deeper branches.
                    if (sz > 4 && $urandom_range(0, 1) == 1)
                        parent = tree_nodes[$urandom_range(sz - 4, sz - 1)];
                    else
                        parent = tree_nodes[$urandom_range(0, sz - 1)];
                    a = rand_node();
                    send_op(make_op(FUNC_ATTACH, a, parent, rand_weight()));
                    tree_nodes = {tree_nodes, a};
                    sent++;
                end else if (choice < 90) begin
                    a = tree_nodes[$urandom_range(0, sz - 1)];
                    b = ($urandom_range(0, 9) == 0) ? a : tree_nodes[$urandom_range(0, sz - 1)];
                    send_op(make_op(FUNC_QUERY, a, b, rand_weight()));
                    sent++;
                end else begin
                    op = make_op(func_t'($urandom_range(0, 1)),
                                 node_t'($urandom_range(0, NODE_COUNT - 1)),
                                 node_t'($urandom_range(0, NODE_COUNT - 1)),
                                 rand_weight());
                    send_op(op);
                    if (!(op.func == FUNC_ATTACH && op.node_a == '0)) sent++;
                end
            end
        end
    endtask

    // The receiver holds off for a long stretch while queries keep coming.
    task automatic test_result_hold();
        wait_drained();
        rx_hold_ticket++;
        for (int n = 0; n < HOLD_QUERIES; n++)
            send_op(make_op(FUNC_QUERY, rand_node(), rand_node(), rand_weight()));
        wait_drained();
    endtask

    // Sample handshakes and result fields in the middle of the cycle.
    always @(negedge aclk) begin
        s_fire <= aresetn && s_tvalid && s_tready;
        m_fire <= aresetn && m_tvalid && m_tready;
        m_word <= m_tdata;
        m_flag <= m_tuser;
    end

    // Receiver: a requested long hold first, otherwise a rotating stall pattern.
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_hold_ticket != rx_hold_served) begin
            rx_hold_served <= rx_hold_ticket;
            rx_hold_left   <= RX_HOLD_CYCLES;
            m_tready       <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            case ((rx_cycle / 160) % 4)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cycle % 7) < 3);
            endcase
        end
    end

    // Compare each accepted result with the oldest owed path minimum.
    always @(posedge aclk) begin
        path_result_t want;
        if (m_fire) begin
            n_results++;
            if (pending_path_mins.size() == 0) begin
                report_mismatch($sformatf("result with none expected: path_min %0d no_edge %0b",
                                          m_word[WEIGHT_W-1:0], m_flag));
            end else begin
                want = pending_path_mins.pop_front();
                if (want.no_edge) n_equal++;
                if (m_word[WEIGHT_W-1:0] !== want.path_min)
                    report_mismatch($sformatf("path_min expected %0d, got %0d",
                                              want.path_min, m_word[WEIGHT_W-1:0]));
                if (m_flag !== want.no_edge)
                    report_mismatch($sformatf("no_edge expected %0b, got %0b",
                                              want.no_edge, m_flag));
                if (m_word[M_TDATA_W-1:WEIGHT_W] !== '0)
                    report_mismatch($sformatf("m_tdata fill bits not zero: %0h", m_word));
            end
        end
    end

    // Watchdog: too long without any transaction on either side ends the run.
    always @(posedge aclk) begin
        if (s_fire || m_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Timeout: no transaction for %0d cycles.", WATCHDOG_CYCLES);
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        for (int n = 0; n < NODE_COUNT; n++) begin
            depth_tbl[n] = '0;
            for (int lvl = 0; lvl < LIFT_LEVELS; lvl++) begin
                anc_tbl[lvl][n]  = '0;
                jmin_tbl[lvl][n] = '0;
            end
        end
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_deep_chain();
        test_random_trees();
        test_result_hold();

        wait_drained();
        repeat (2 * LIFT_LEVELS + 10) @(posedge aclk);
        if (pending_path_mins.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      pending_path_mins.size()));

        $display("Ran %0d attach and %0d query transactions; %0d results checked, %0d equal.",
                 n_attach, n_query, n_results, n_equal);
        $display("Deepest predicted node depth %0d; %0d mismatches.", max_depth, error_count);
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
